// ----- src/arcade_io_shifter_and_frame_irq_assert.svh -----
// assertion helpers used by the block's core module
`ifndef ARCADE_IO_SHIFTER_AND_FRAME_IRQ_ASSERT_SVH
`define ARCADE_IO_SHIFTER_AND_FRAME_IRQ_ASSERT_SVH

// same-cycle implication, held off during reset
`define AIO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define AIO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/aio_pkg.sv -----
`default_nettype none

package aio_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;

    localparam logic [7:0] PORT_CONST   = 8'd0;
    localparam logic [7:0] PORT_BTN_ONE = 8'd1;
    localparam logic [7:0] PORT_BTN_TWO = 8'd2;
    localparam logic [7:0] PORT_SHIFT_R = 8'd3;
    localparam logic [7:0] PORT_AMOUNT  = 8'd2;
    localparam logic [7:0] PORT_SOUND_A = 8'd3;
    localparam logic [7:0] PORT_PUSH    = 8'd4;
    localparam logic [7:0] PORT_SOUND_B = 8'd5;

    localparam logic [4:0]  IO_CYCLES        = 5'd3;
    localparam logic [15:0] HALF_FRAME_RESET = 16'd16666;
    localparam logic [1:0]  VECTOR_FIRST     = 2'd1;
    localparam logic [1:0]  VECTOR_SECOND    = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] port;
        logic [7:0] write_data;
        logic [4:0] cycle_count;
        logic [7:0] buttons_one;
        logic [7:0] buttons_two;
        logic       irq_enabled;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_port;
        logic       sound_valid;
        logic       sound_bank;
        logic [7:0] sound_bits;
        logic       irq_valid;
        logic [1:0] irq_vector;
    } result_t;

    // pipeline control from the input stage to the core and output stage
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

`default_nettype wire

// ----- src/aio_in_stage.sv -----
`default_nettype none

module aio_in_stage (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire aio_pkg::in_item_t in_item,
    input  wire                    out_free,
    output aio_pkg::in_item_t      item,
    output aio_pkg::stage_ctrl_t   ctrl
);

    logic              valid_reg;
    logic              valid_next;
    aio_pkg::in_item_t item_reg;
    logic              advance;

    assign advance  = valid_reg && out_free;
    assign in_ready = !valid_reg || out_free;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item         = item_reg;
    assign ctrl.valid   = valid_reg;
    assign ctrl.advance = advance;

endmodule

`default_nettype wire

// ----- src/aio_core.sv -----
`default_nettype none

`include "arcade_io_shifter_and_frame_irq_assert.svh"

module aio_core (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_wr_en,
    input  wire [15:0]                cfg_wr_data,
    input  wire aio_pkg::in_item_t    item,
    input  wire aio_pkg::stage_ctrl_t ctrl,
    output aio_pkg::result_t          result
);

    logic [15:0] limit_reg;
    logic [7:0]  shift_high_reg, shift_high_next;
    logic [7:0]  shift_low_reg, shift_low_next;
    logic [2:0]  amount_reg, amount_next;
    logic [7:0]  sound_a_reg, sound_a_next;
    logic [7:0]  sound_b_reg, sound_b_next;
    logic [16:0] cycles_reg, cycles_next;
    logic        half_index_reg, half_index_next;
    logic [1:0]  vector_reg, vector_next;

    logic [15:0] pair;
    logic [3:0]  shift_by;
    logic [15:0] pair_shifted;
    logic [4:0]  add;
    logic [16:0] sum;

    assign pair         = {shift_high_reg, shift_low_reg};
    assign shift_by     = 4'd8 - {1'b0, amount_reg};
    assign pair_shifted = pair >> shift_by;

    always_comb begin
        shift_high_next = shift_high_reg;
        shift_low_next  = shift_low_reg;
        amount_next     = amount_reg;
        sound_a_next    = sound_a_reg;
        sound_b_next    = sound_b_reg;
        half_index_next = half_index_reg;
        vector_next     = vector_reg;
        result          = '0;
        add             = item.cycle_count;

        if (item.kind == aio_pkg::KIND_READ) begin
            add = aio_pkg::IO_CYCLES;
            unique case (item.port)
                aio_pkg::PORT_CONST:   result.read_data = 8'd1;
                aio_pkg::PORT_BTN_ONE: result.read_data = item.buttons_one;
                aio_pkg::PORT_BTN_TWO: result.read_data = item.buttons_two;
                aio_pkg::PORT_SHIFT_R: result.read_data = pair_shifted[7:0];
                default:               result.bad_port  = 1'b1;
            endcase
        end else if (item.kind == aio_pkg::KIND_WRITE) begin
            add = aio_pkg::IO_CYCLES;
            unique case (item.port)
                aio_pkg::PORT_AMOUNT: amount_next = item.write_data[2:0];
                aio_pkg::PORT_SOUND_A: begin
                    if (item.write_data != sound_a_reg) begin
                        sound_a_next       = item.write_data;
                        result.sound_valid = 1'b1;
                        result.sound_bits  = item.write_data;
                    end
                end
                aio_pkg::PORT_PUSH: begin
                    shift_low_next  = shift_high_reg;
                    shift_high_next = item.write_data;
                end
                aio_pkg::PORT_SOUND_B: begin
                    if (item.write_data != sound_b_reg) begin
                        sound_b_next       = item.write_data;
                        result.sound_valid = 1'b1;
                        result.sound_bank  = 1'b1;
                        result.sound_bits  = item.write_data;
                    end
                end
                default: ;
            endcase
        end

        sum         = cycles_reg + {12'd0, add};
        cycles_next = sum;
        if (sum >= {1'b0, limit_reg}) begin
            cycles_next = '0;
            if (item.irq_enabled) begin
                result.irq_valid  = 1'b1;
                result.irq_vector = vector_reg;
                vector_next = (vector_reg == aio_pkg::VECTOR_FIRST) ?
                              aio_pkg::VECTOR_SECOND : aio_pkg::VECTOR_FIRST;
            end
            // second half of a frame restarts the vector sequence
            if (half_index_reg) begin
                vector_next = aio_pkg::VECTOR_FIRST;
            end
            half_index_next = ~half_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= aio_pkg::HALF_FRAME_RESET;
            shift_high_reg <= '0;
            shift_low_reg  <= '0;
            amount_reg     <= '0;
            sound_a_reg    <= '0;
            sound_b_reg    <= '0;
            cycles_reg     <= '0;
            half_index_reg <= 1'b0;
            vector_reg     <= aio_pkg::VECTOR_FIRST;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (ctrl.advance) begin
                shift_high_reg <= shift_high_next;
                shift_low_reg  <= shift_low_next;
                amount_reg     <= amount_next;
                sound_a_reg    <= sound_a_next;
                sound_b_reg    <= sound_b_next;
                cycles_reg     <= cycles_next;
                half_index_reg <= half_index_next;
                vector_reg     <= vector_next;
            end
        end
    end

    `AIO_ASSERT_IMPL(a_first_half_vector, aclk, aresetn, !half_index_reg,
        vector_reg == aio_pkg::VECTOR_FIRST, "vector not 1 at start of frame")
    `AIO_ASSERT_IMPL(a_irq_vector_range, aclk, aresetn, ctrl.advance && result.irq_valid,
        result.irq_vector == aio_pkg::VECTOR_FIRST ||
        result.irq_vector == aio_pkg::VECTOR_SECOND, "irq vector out of range")
    `AIO_ASSERT_IMPL(a_bad_port_no_data, aclk, aresetn, ctrl.advance && result.bad_port,
        result.read_data == 8'd0 && !result.sound_valid, "bad port read carries data")
    `AIO_ASSERT_IMPL(a_advance_needs_word, aclk, aresetn, ctrl.advance,
        ctrl.valid, "core advanced without a held word")

endmodule

`default_nettype wire

// ----- src/aio_out_stage.sv -----
`default_nettype none

module aio_out_stage (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire aio_pkg::stage_ctrl_t ctrl,
    input  wire aio_pkg::result_t     result,
    output logic                      out_free,
    output logic                      out_valid,
    input  wire                       out_ready,
    output aio_pkg::result_t          out_result
);

    logic             valid_reg;
    logic             valid_next;
    aio_pkg::result_t result_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.advance) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ----- src/arcade_io_shifter_and_frame_irq.sv -----
// an s_ word goes into the input register, its result into the result register (m_tvalid)
// throughput: one word per cycle while the result is not stalled, set by the state update
// computed combinationally between the input register and the result register
// a stalled result holds the pipeline; s_tready follows m_tready while both stages are full
// reset clears both stage valids, the shift pair, sound history, cycle count and half index,
// sets the next vector to 1 and the half-frame limit to 16666
`default_nettype none

module arcade_io_shifter_and_frame_irq (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    // port[7:0], write_data[15:8], cycle_count[20:16], buttons_one[28:21],
    // buttons_two[36:29], irq_enabled[37], zero[39:38]
    input  wire  [39:0] s_tdata,
    // kind[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // read_data[7:0], bad_port[8], sound_valid[9], sound_bits[17:10],
    // irq_valid[18], irq_vector[20:19], zero[23:21]
    output logic [23:0] m_tdata,
    // sound_bank[0]
    output logic [0:0]  m_tuser
);

    aio_pkg::in_item_t    in_item;
    aio_pkg::in_item_t    item;
    aio_pkg::stage_ctrl_t ctrl;
    aio_pkg::result_t     result;
    aio_pkg::result_t     out_result;
    logic                 out_free;

    assign in_item.kind        = s_tuser;
    assign in_item.port        = s_tdata[7:0];
    assign in_item.write_data  = s_tdata[15:8];
    assign in_item.cycle_count = s_tdata[20:16];
    assign in_item.buttons_one = s_tdata[28:21];
    assign in_item.buttons_two = s_tdata[36:29];
    assign in_item.irq_enabled = s_tdata[37];

    aio_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .item     (item),
        .ctrl     (ctrl)
    );

    aio_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .ctrl        (ctrl),
        .result      (result)
    );

    aio_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {3'b000, out_result.irq_vector, out_result.irq_valid,
                      out_result.sound_bits, out_result.sound_valid,
                      out_result.bad_port, out_result.read_data};
    assign m_tuser = out_result.sound_bank;

endmodule

`default_nettype wire
